/* rtl/csc_pkg.sv */
package csc_pkg;

    localparam int MaxTagsDefault = 16;

    localparam logic [2:0] OP_START    = 3'd0;
    localparam logic [2:0] OP_READY    = 3'd1;
    localparam logic [2:0] OP_ARM      = 3'd2;
    localparam logic [2:0] OP_ARMED    = 3'd3;
    localparam logic [2:0] OP_COMPLETE = 3'd4;
    localparam logic [2:0] OP_FINALIZE = 3'd5;
    localparam logic [2:0] OP_CANCEL   = 3'd6;

    localparam logic [2:0] R_ACCEPTED  = 3'd0;
    localparam logic [2:0] R_DUPLICATE = 3'd1;
    localparam logic [2:0] R_CONFLICT  = 3'd2;
    localparam logic [2:0] R_STALE     = 3'd3;
    localparam logic [2:0] R_BUSY      = 3'd4;
    localparam logic [2:0] R_ALREADY   = 3'd5;
    localparam logic [2:0] R_ORDER     = 3'd6;

    localparam logic [1:0] PH_INACTIVE   = 2'd0;
    localparam logic [1:0] PH_STARTING   = 2'd1;
    localparam logic [1:0] PH_READY      = 2'd2;
    localparam logic [1:0] PH_COLLECTING = 2'd3;

    localparam logic [1:0] DISP_NONE      = 2'd0;
    localparam logic [1:0] DISP_FINALIZED = 2'd1;
    localparam logic [1:0] DISP_CANCELLED = 2'd2;

    typedef struct packed {
        logic [2:0]  op;
        logic [31:0] collection_id;
        logic [31:0] slice_id;
        logic [31:0] tag_id;
        logic        tag_present;
        logic        last;
        logic [31:0] heading_bits;
    } cmd_t;

    typedef struct packed {
        logic [2:0] result;
        logic [1:0] phase;
    } rsp_t;

endpackage

/* rtl/collection_slice_coordinator_top.sv */
// Collection slice coordinator.
// Command channel: present cmd with start high; the command transfers at a
// rising edge where start is high and busy is low. Commands are start
// (one transfer per tag, only the one with last set is answered), ready,
// arm, armed, complete, finalize, cancel.
// Response channel: rsp is valid for exactly one cycle while done is high;
// the receiver cannot hold it off. Each answered command yields one rsp.
// Tag tables live in two synchronous memories (expected, staged); a search
// reads one entry at a time and compares it once the read returns. A command
// other than start searches the expected table (up to MAX_TAGS entries) for
// its tag, then executes and answers. A start transfer first searches the
// staged set. A final start then copies the set when inactive, or walks it
// against the expected table when active, searching it for each staged tag.
// Busy drops in the cycle done rises; the next transfer can land there.
// Per-entry ready/armed/completed bits are flip-flops cleared at once.
// Reset (rst_n low, asynchronous) returns to inactive with empty tables;
// no clearing pass is needed, the counts bound every read.
module collection_slice_coordinator_top #(
    parameter int MAX_TAGS = csc_pkg::MaxTagsDefault
) (
    input  logic          clk,
    input  logic          rst_n,
    input  logic          start,
    input  csc_pkg::cmd_t cmd,
    output logic          busy,
    output logic          done,
    output csc_pkg::rsp_t rsp
);
    import csc_pkg::*;

    localparam int IW = (MAX_TAGS > 1) ? $clog2(MAX_TAGS) : 1;
    localparam int CW = $clog2(MAX_TAGS + 1);

    localparam logic [3:0] S_IDLE   = 4'd0;
    localparam logic [3:0] S_SSCAN  = 4'd1; // search staged for new tag
    localparam logic [3:0] S_SCHK   = 4'd2;
    localparam logic [3:0] S_ESCAN  = 4'd3; // search expected for tag
    localparam logic [3:0] S_ECHK   = 4'd4;
    localparam logic [3:0] S_CRD    = 4'd5; // copy staged -> expected
    localparam logic [3:0] S_CWR    = 4'd6;
    localparam logic [3:0] S_DRD    = 4'd7; // duplicate check outer read
    localparam logic [3:0] S_DLAT   = 4'd8;
    localparam logic [3:0] S_DSCAN  = 4'd9;
    localparam logic [3:0] S_DCHK   = 4'd10;
    localparam logic [3:0] S_EXEC   = 4'd11;

    logic [3:0] state_reg, state_next;

    logic [31:0] exp_mem [MAX_TAGS];
    logic [31:0] stg_mem [MAX_TAGS];
    logic [31:0] exp_rd, stg_rd;
    logic        exp_we, stg_we;
    logic [IW-1:0] exp_ra, stg_ra, exp_wa, stg_wa;
    logic [31:0] exp_wd, stg_wd;

    always_ff @(posedge clk)
    begin
        if (exp_we)
        begin
            exp_mem[exp_wa] <= exp_wd;
        end
        exp_rd <= exp_mem[exp_ra];
    end

    always_ff @(posedge clk)
    begin
        if (stg_we)
        begin
            stg_mem[stg_wa] <= stg_wd;
        end
        stg_rd <= stg_mem[stg_ra];
    end

    cmd_t        cmd_reg;
    logic [CW-1:0] idx_reg, idx_next, oidx_reg, oidx_next;
    logic        found_reg, found_next;
    logic [IW-1:0] kidx_reg, kidx_next;
    logic [31:0] key_reg, key_next;
    logic        same_reg, same_next;

    logic [1:0]  cstate_reg, cstate_next;
    logic [31:0] cur_coll_reg, cur_coll_next;
    logic [31:0] next_slice_reg, next_slice_next;
    logic [31:0] act_slice_reg, act_slice_next;
    logic        act_valid_reg, act_valid_next;
    logic [31:0] done_slice_reg, done_slice_next;
    logic        done_valid_reg, done_valid_next;
    logic [31:0] act_head_reg, act_head_next;
    logic [31:0] fin_coll_reg, fin_coll_next;
    logic [1:0]  fin_disp_reg, fin_disp_next;
    logic [CW-1:0] exp_cnt_reg, exp_cnt_next;
    logic [CW-1:0] rdy_cnt_reg, rdy_cnt_next;
    logic [CW-1:0] cmp_cnt_reg, cmp_cnt_next;
    logic [CW-1:0] stg_cnt_reg, stg_cnt_next;
    logic        stg_ovf_reg, stg_ovf_next;
    logic [MAX_TAGS-1:0] rdy_bits_reg, rdy_bits_next;
    logic [MAX_TAGS-1:0] arm_bits_reg, arm_bits_next;
    logic [MAX_TAGS-1:0] cmp_bits_reg, cmp_bits_next;
    logic        done_next;
    rsp_t        rsp_next;

    assign busy = (state_reg != S_IDLE);

    always_comb
    begin
        logic [2:0] res;
        logic       k_ok;
        logic       mt;
        state_next = state_reg;
        idx_next = idx_reg;
        oidx_next = oidx_reg;
        found_next = found_reg;
        kidx_next = kidx_reg;
        key_next = key_reg;
        same_next = same_reg;
        cstate_next = cstate_reg;
        cur_coll_next = cur_coll_reg;
        next_slice_next = next_slice_reg;
        act_slice_next = act_slice_reg;
        act_valid_next = act_valid_reg;
        done_slice_next = done_slice_reg;
        done_valid_next = done_valid_reg;
        act_head_next = act_head_reg;
        fin_coll_next = fin_coll_reg;
        fin_disp_next = fin_disp_reg;
        exp_cnt_next = exp_cnt_reg;
        rdy_cnt_next = rdy_cnt_reg;
        cmp_cnt_next = cmp_cnt_reg;
        stg_cnt_next = stg_cnt_reg;
        stg_ovf_next = stg_ovf_reg;
        rdy_bits_next = rdy_bits_reg;
        arm_bits_next = arm_bits_reg;
        cmp_bits_next = cmp_bits_reg;
        done_next = 1'b0;
        rsp_next = rsp;
        exp_we = 1'b0;
        stg_we = 1'b0;
        exp_wa = idx_reg[IW-1:0];
        stg_wa = stg_cnt_reg[IW-1:0];
        exp_wd = stg_rd;
        stg_wd = cmd_reg.tag_id;
        exp_ra = idx_reg[IW-1:0];
        stg_ra = idx_reg[IW-1:0];
        res = R_CONFLICT;
        k_ok = found_reg;
        mt = (cstate_reg != PH_INACTIVE) && (cur_coll_reg == cmd_reg.collection_id);

        case (state_reg)
            S_IDLE:
            begin
                if (start)
                begin
                    idx_next = '0;
                    found_next = 1'b0;
                    key_next = cmd.tag_id;
                    if (cmd.op == OP_START)
                    begin
                        state_next = S_SSCAN;
                    end
                    else
                    begin
                        // any other command drops a partial start run
                        stg_cnt_next = '0;
                        stg_ovf_next = 1'b0;
                        state_next = S_ESCAN;
                    end
                end
            end
            S_SSCAN:
            begin
                if (found_reg || idx_reg >= stg_cnt_reg)
                begin
                    if (cmd_reg.tag_present && !found_reg)
                    begin
                        if (stg_cnt_reg < CW'(MAX_TAGS))
                        begin
                            stg_we = 1'b1;
                            stg_cnt_next = stg_cnt_reg + 1'b1;
                        end
                        else
                        begin
                            stg_ovf_next = 1'b1;
                        end
                    end
                    if (!cmd_reg.last)
                    begin
                        state_next = S_IDLE;
                    end
                    else if (cstate_reg != PH_INACTIVE)
                    begin
                        same_next = 1'b1;
                        oidx_next = '0;
                        state_next = S_DRD;
                    end
                    else
                    begin
                        idx_next = '0;
                        state_next = S_CRD;
                    end
                end
                else
                begin
                    state_next = S_SCHK;
                end
            end
            S_SCHK:
            begin
                if (stg_rd == key_reg)
                begin
                    found_next = 1'b1;
                end
                idx_next = idx_reg + 1'b1;
                state_next = S_SSCAN;
            end
            S_ESCAN:
            begin
                if (found_reg || idx_reg >= exp_cnt_reg)
                begin
                    state_next = (cmd_reg.op == OP_START) ? S_DRD : S_EXEC;
                    if (cmd_reg.op == OP_START)
                    begin
                        if (!found_reg)
                        begin
                            same_next = 1'b0;
                        end
                        oidx_next = oidx_reg + 1'b1;
                    end
                end
                else
                begin
                    state_next = S_ECHK;
                end
            end
            S_ECHK:
            begin
                if (exp_rd == key_reg)
                begin
                    found_next = 1'b1;
                    kidx_next = idx_reg[IW-1:0];
                end
                else
                begin
                    idx_next = idx_reg + 1'b1;
                end
                state_next = S_ESCAN;
            end
            S_DRD:
            begin
                stg_ra = oidx_reg[IW-1:0];
                if (!same_reg || stg_ovf_reg || cur_coll_reg != cmd_reg.collection_id
                    || stg_cnt_reg != exp_cnt_reg || oidx_reg >= stg_cnt_reg)
                begin
                    rsp_next.result = (same_reg && !stg_ovf_reg
                        && cur_coll_reg == cmd_reg.collection_id
                        && stg_cnt_reg == exp_cnt_reg) ? R_DUPLICATE : R_CONFLICT;
                    rsp_next.phase = cstate_reg;
                    done_next = 1'b1;
                    stg_cnt_next = '0;
                    stg_ovf_next = 1'b0;
                    state_next = S_IDLE;
                end
                else
                begin
                    state_next = S_DLAT;
                end
            end
            S_DLAT:
            begin
                key_next = stg_rd;
                idx_next = '0;
                found_next = 1'b0;
                state_next = S_ESCAN;
            end
            S_CRD:
            begin
                if (cmd_reg.collection_id == 32'd0 || stg_cnt_reg == '0 || stg_ovf_reg)
                begin
                    rsp_next.result = R_CONFLICT;
                    rsp_next.phase = cstate_reg;
                    done_next = 1'b1;
                    stg_cnt_next = '0;
                    stg_ovf_next = 1'b0;
                    state_next = S_IDLE;
                end
                else if (idx_reg >= stg_cnt_reg)
                begin
                    cur_coll_next = cmd_reg.collection_id;
                    exp_cnt_next = stg_cnt_reg;
                    rdy_bits_next = '0;
                    rdy_cnt_next = '0;
                    arm_bits_next = '0;
                    cmp_bits_next = '0;
                    cmp_cnt_next = '0;
                    next_slice_next = 32'd1;
                    act_valid_next = 1'b0;
                    done_valid_next = 1'b0;
                    cstate_next = PH_STARTING;
                    rsp_next.result = R_ACCEPTED;
                    rsp_next.phase = PH_STARTING;
                    done_next = 1'b1;
                    stg_cnt_next = '0;
                    stg_ovf_next = 1'b0;
                    state_next = S_IDLE;
                end
                else
                begin
                    state_next = S_CWR;
                end
            end
            S_CWR:
            begin
                exp_we = 1'b1;
                idx_next = idx_reg + 1'b1;
                state_next = S_CRD;
            end
            S_EXEC:
            begin
                case (cmd_reg.op)
                    OP_READY:
                    begin
                        if (!mt)
                        begin
                            res = R_STALE;
                        end
                        else if (cstate_reg != PH_STARTING)
                        begin
                            res = (k_ok && rdy_bits_reg[kidx_reg]) ? R_DUPLICATE : R_CONFLICT;
                        end
                        else if (!k_ok)
                        begin
                            res = R_CONFLICT;
                        end
                        else if (rdy_bits_reg[kidx_reg])
                        begin
                            res = R_DUPLICATE;
                        end
                        else
                        begin
                            rdy_bits_next[kidx_reg] = 1'b1;
                            rdy_cnt_next = rdy_cnt_reg + 1'b1;
                            if (rdy_cnt_next == exp_cnt_reg)
                            begin
                                cstate_next = PH_READY;
                            end
                            res = R_ACCEPTED;
                        end
                    end
                    OP_ARM:
                    begin
                        if (!mt)
                        begin
                            res = R_STALE;
                        end
                        else if (cstate_reg == PH_COLLECTING)
                        begin
                            res = (act_valid_reg && act_slice_reg == cmd_reg.slice_id
                                && act_head_reg == cmd_reg.heading_bits)
                                ? R_DUPLICATE : R_BUSY;
                        end
                        else if (cstate_reg != PH_READY)
                        begin
                            res = R_BUSY;
                        end
                        else if (done_valid_reg && done_slice_reg == cmd_reg.slice_id)
                        begin
                            res = R_ALREADY;
                        end
                        else if (cmd_reg.slice_id != next_slice_reg)
                        begin
                            res = R_ORDER;
                        end
                        else
                        begin
                            act_slice_next = cmd_reg.slice_id;
                            act_valid_next = 1'b1;
                            act_head_next = cmd_reg.heading_bits;
                            arm_bits_next = '0;
                            cmp_bits_next = '0;
                            cmp_cnt_next = '0;
                            cstate_next = PH_COLLECTING;
                            res = R_ACCEPTED;
                        end
                    end
                    OP_ARMED, OP_COMPLETE:
                    begin
                        if (!mt || !act_valid_reg || act_slice_reg != cmd_reg.slice_id)
                        begin
                            res = R_STALE;
                        end
                        else if (cstate_reg != PH_COLLECTING || !k_ok)
                        begin
                            res = R_CONFLICT;
                        end
                        else if (cmd_reg.op == OP_ARMED)
                        begin
                            if (arm_bits_reg[kidx_reg])
                            begin
                                res = R_DUPLICATE;
                            end
                            else
                            begin
                                arm_bits_next[kidx_reg] = 1'b1;
                                res = R_ACCEPTED;
                            end
                        end
                        else if (cmp_bits_reg[kidx_reg])
                        begin
                            res = R_DUPLICATE;
                        end
                        else
                        begin
                            cmp_bits_next[kidx_reg] = 1'b1;
                            cmp_cnt_next = cmp_cnt_reg + 1'b1;
                            if (cmp_cnt_next == exp_cnt_reg)
                            begin
                                cstate_next = PH_READY;
                                done_slice_next = act_slice_reg;
                                done_valid_next = 1'b1;
                                act_valid_next = 1'b0;
                                next_slice_next = next_slice_reg + 32'd1;
                            end
                            res = R_ACCEPTED;
                        end
                    end
                    OP_FINALIZE, OP_CANCEL:
                    begin
                        if (cstate_reg == PH_INACTIVE)
                        begin
                            res = (cmd_reg.collection_id == fin_coll_reg
                                && fin_disp_reg == ((cmd_reg.op == OP_FINALIZE)
                                ? DISP_FINALIZED : DISP_CANCELLED)) ? R_DUPLICATE : R_STALE;
                        end
                        else if (!mt)
                        begin
                            res = R_STALE;
                        end
                        else if (cmd_reg.op == OP_FINALIZE && cstate_reg != PH_READY)
                        begin
                            res = R_BUSY;
                        end
                        else
                        begin
                            fin_coll_next = cur_coll_reg;
                            fin_disp_next = (cmd_reg.op == OP_FINALIZE)
                                ? DISP_FINALIZED : DISP_CANCELLED;
                            cur_coll_next = '0;
                            exp_cnt_next = '0;
                            rdy_bits_next = '0;
                            rdy_cnt_next = '0;
                            arm_bits_next = '0;
                            cmp_bits_next = '0;
                            cmp_cnt_next = '0;
                            next_slice_next = 32'd1;
                            act_valid_next = 1'b0;
                            done_valid_next = 1'b0;
                            cstate_next = PH_INACTIVE;
                            res = R_ACCEPTED;
                        end
                    end
                    default:
                    begin
                        res = R_CONFLICT;
                    end
                endcase
                rsp_next.result = res;
                rsp_next.phase = cstate_next;
                done_next = 1'b1;
                state_next = S_IDLE;
            end
            default:
            begin
                state_next = S_IDLE;
            end
        endcase
    end

    always_ff @(posedge clk)
    begin
        if (start && !busy)
        begin
            cmd_reg <= cmd;
        end
        idx_reg <= idx_next;
        oidx_reg <= oidx_next;
        found_reg <= found_next;
        kidx_reg <= kidx_next;
        key_reg <= key_next;
        same_reg <= same_next;
        rsp <= rsp_next;
        act_slice_reg <= act_slice_next;
        done_slice_reg <= done_slice_next;
        act_head_reg <= act_head_next;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= S_IDLE;
            done <= 1'b0;
            cstate_reg <= PH_INACTIVE;
            cur_coll_reg <= '0;
            next_slice_reg <= 32'd1;
            act_valid_reg <= 1'b0;
            done_valid_reg <= 1'b0;
            fin_coll_reg <= '0;
            fin_disp_reg <= DISP_NONE;
            exp_cnt_reg <= '0;
            rdy_cnt_reg <= '0;
            cmp_cnt_reg <= '0;
            stg_cnt_reg <= '0;
            stg_ovf_reg <= 1'b0;
            rdy_bits_reg <= '0;
            arm_bits_reg <= '0;
            cmp_bits_reg <= '0;
        end
        else
        begin
            state_reg <= state_next;
            done <= done_next;
            cstate_reg <= cstate_next;
            cur_coll_reg <= cur_coll_next;
            next_slice_reg <= next_slice_next;
            act_valid_reg <= act_valid_next;
            done_valid_reg <= done_valid_next;
            fin_coll_reg <= fin_coll_next;
            fin_disp_reg <= fin_disp_next;
            exp_cnt_reg <= exp_cnt_next;
            rdy_cnt_reg <= rdy_cnt_next;
            cmp_cnt_reg <= cmp_cnt_next;
            stg_cnt_reg <= stg_cnt_next;
            stg_ovf_reg <= stg_ovf_next;
            rdy_bits_reg <= rdy_bits_next;
            arm_bits_reg <= arm_bits_next;
            cmp_bits_reg <= cmp_bits_next;
        end
    end

`ifndef SYNTHESIS
    a_cnt_bound: assert property (@(posedge clk) disable iff (!rst_n)
        exp_cnt_reg <= CW'(MAX_TAGS) && stg_cnt_reg <= CW'(MAX_TAGS))
        else $error("table count beyond capacity");
    a_rdy_bound: assert property (@(posedge clk) disable iff (!rst_n)
        rdy_cnt_reg <= exp_cnt_reg && cmp_cnt_reg <= exp_cnt_reg)
        else $error("ready/complete count exceeds expected count");
    a_done_busy: assert property (@(posedge clk) disable iff (!rst_n)
        done |-> !busy)
        else $error("response while still busy");
    a_inactive_empty: assert property (@(posedge clk) disable iff (!rst_n)
        cstate_reg == PH_INACTIVE |-> exp_cnt_reg == '0 && !act_valid_reg)
        else $error("inactive with live table");
`endif

endmodule

/* dv/collection_slice_coordinator_top_test.sv */
`default_nettype none

module collection_slice_coordinator_top_test;
    timeunit 1ns;
    timeprecision 1ps;

    import csc_pkg::*;

    localparam int NumTags    = 16;
    localparam int RandItems  = 600;
    localparam int QuietTail  = 80;   // last commands go out with no idling
    localparam int StallLimit = 4000; // cycles with no transfer and no answer
    localparam int DrainWait  = 400;  // a trailing unanswered start settles well within this

    logic  clk;
    logic  rst_n;
    logic  start;
    cmd_t  cmd;
    logic  busy;
    logic  done;
    rsp_t  rsp;

    collection_slice_coordinator_top DUT (
        .clk   (clk),
        .rst_n (rst_n),
        .start (start),
        .cmd   (cmd),
        .busy  (busy),
        .done  (done),
        .rsp   (rsp)
    );

    always
    begin
        clk = 1'b0;
        #6;
        clk = 1'b1;
        #6;
    end

    // Commands waiting to transfer; a set hold bit makes the driver wait until
    // every answer owed so far has come back before that command goes out.
    cmd_t cmd_pending[$];
    bit   hold_pending[$];
    rsp_t rsp_expected[$];
    int   fail_count;
    int   stall_cycles;

    // Shadow copy of the coordinator state.
    logic [1:0]  sh_phase;
    logic [31:0] sh_collection;
    logic [31:0] sh_next_slice;
    logic [31:0] sh_active_slice;
    logic        sh_active_valid;
    logic [31:0] sh_done_slice;
    logic        sh_done_valid;
    logic [31:0] sh_heading;
    logic [31:0] sh_fin_collection;
    logic [1:0]  sh_fin_disp;
    logic [31:0] sh_exp_tags [NumTags];
    int          sh_exp_count;
    logic        sh_ready   [NumTags];
    logic        sh_armed   [NumTags];
    logic        sh_complete[NumTags];
    int          sh_ready_count;
    int          sh_complete_count;
    logic [31:0] sh_stage_tags [NumTags];
    int          sh_stage_count;
    logic        sh_stage_over;

    function automatic int tag_slot(logic [31:0] tag);
        for (int i = 0; i < sh_exp_count; i++)
            if (sh_exp_tags[i] == tag)
                return i;
        return -1;
    endfunction

    function automatic void clear_slice_marks();
        for (int i = 0; i < NumTags; i++)
        begin
            sh_armed[i]    = 1'b0;
            sh_complete[i] = 1'b0;
        end
        sh_complete_count = 0;
    endfunction

    function automatic void clear_tag_table();
        sh_exp_count   = 0;
        sh_ready_count = 0;
        for (int i = 0; i < NumTags; i++)
            sh_ready[i] = 1'b0;
        clear_slice_marks();
        sh_next_slice   = 32'd1;
        sh_active_valid = 1'b0;
        sh_done_valid   = 1'b0;
    endfunction

    function automatic void shadow_reset();
        sh_phase          = PH_INACTIVE;
        sh_collection     = '0;
        sh_active_slice   = '0;
        sh_done_slice     = '0;
        sh_heading        = '0;
        sh_fin_collection = '0;
        sh_fin_disp       = DISP_NONE;
        clear_tag_table();
        sh_stage_count = 0;
        sh_stage_over  = 1'b0;
    endfunction

    function automatic logic [2:0] answer_start(logic [31:0] cid);
        logic same;
        if (sh_phase != PH_INACTIVE)
        begin
            same = !sh_stage_over && sh_collection == cid && sh_stage_count == sh_exp_count;
            for (int i = 0; same && i < sh_stage_count; i++)
                if (tag_slot(sh_stage_tags[i]) < 0)
                    same = 1'b0;
            return same ? R_DUPLICATE : R_CONFLICT;
        end
        if (cid == 0 || sh_stage_count == 0 || sh_stage_over)
            return R_CONFLICT;
        sh_collection = cid;
        clear_tag_table();
        for (int i = 0; i < sh_stage_count; i++)
            sh_exp_tags[i] = sh_stage_tags[i];
        sh_exp_count = sh_stage_count;
        sh_phase     = PH_STARTING;
        return R_ACCEPTED;
    endfunction

    function automatic logic [2:0] answer_ready(logic [31:0] cid, logic [31:0] tag);
        int k;
        k = tag_slot(tag);
        if (sh_phase == PH_INACTIVE || sh_collection != cid)
            return R_STALE;
        if (sh_phase != PH_STARTING)
            return (k >= 0 && sh_ready[k]) ? R_DUPLICATE : R_CONFLICT;
        if (k < 0)
            return R_CONFLICT;
        if (sh_ready[k])
            return R_DUPLICATE;
        sh_ready[k] = 1'b1;
        sh_ready_count++;
        if (sh_ready_count == sh_exp_count)
            sh_phase = PH_READY;
        return R_ACCEPTED;
    endfunction

    function automatic logic [2:0] answer_arm(logic [31:0] cid, logic [31:0] slice,
                                              logic [31:0] heading);
        if (sh_phase == PH_INACTIVE || sh_collection != cid)
            return R_STALE;
        if (sh_phase == PH_COLLECTING)
            return (sh_active_valid && sh_active_slice == slice && sh_heading == heading)
                   ? R_DUPLICATE : R_BUSY;
        if (sh_phase != PH_READY)
            return R_BUSY;
        if (sh_done_valid && sh_done_slice == slice)
            return R_ALREADY;
        if (slice != sh_next_slice)
            return R_ORDER;
        sh_active_slice = slice;
        sh_active_valid = 1'b1;
        sh_heading      = heading;
        clear_slice_marks();
        sh_phase = PH_COLLECTING;
        return R_ACCEPTED;
    endfunction

    function automatic logic [2:0] answer_mark(logic [31:0] cid, logic [31:0] slice,
                                               logic [31:0] tag, bit finish_mark);
        int k;
        if (sh_phase == PH_INACTIVE || sh_collection != cid || !sh_active_valid
            || sh_active_slice != slice)
            return R_STALE;
        k = tag_slot(tag);
        if (sh_phase != PH_COLLECTING || k < 0)
            return R_CONFLICT;
        if (!finish_mark)
        begin
            if (sh_armed[k])
                return R_DUPLICATE;
            sh_armed[k] = 1'b1;
            return R_ACCEPTED;
        end
        if (sh_complete[k])
            return R_DUPLICATE;
        sh_complete[k] = 1'b1;
        sh_complete_count++;
        if (sh_complete_count == sh_exp_count)
        begin
            sh_phase        = PH_READY;
            sh_done_slice   = sh_active_slice;
            sh_done_valid   = 1'b1;
            sh_active_valid = 1'b0;
            sh_next_slice   = sh_next_slice + 32'd1;
        end
        return R_ACCEPTED;
    endfunction

    function automatic logic [2:0] answer_close(logic [31:0] cid, logic [1:0] disp);
        if (sh_phase == PH_INACTIVE)
            return (cid == sh_fin_collection && sh_fin_disp == disp) ? R_DUPLICATE : R_STALE;
        if (sh_collection != cid)
            return R_STALE;
        if (disp == DISP_FINALIZED && sh_phase != PH_READY)
            return R_BUSY;
        sh_fin_collection = sh_collection;
        sh_fin_disp       = disp;
        sh_collection     = '0;
        clear_tag_table();
        sh_phase = PH_INACTIVE;
        return R_ACCEPTED;
    endfunction

    // Advance the shadow state by one command; return 1 with the answer when
    // the command is answered.
    function automatic bit coord_predict(cmd_t c, output rsp_t r);
        logic [2:0] code;
        logic       known;
        r = '0;
        if (c.op == OP_START)
        begin
            if (c.tag_present)
            begin
                known = 1'b0;
                for (int i = 0; i < sh_stage_count; i++)
                    if (sh_stage_tags[i] == c.tag_id)
                        known = 1'b1;
                if (!known)
                begin
                    if (sh_stage_count < NumTags)
                        sh_stage_tags[sh_stage_count++] = c.tag_id;
                    else
                        sh_stage_over = 1'b1;
                end
            end
            if (!c.last)
                return 1'b0;
            code = answer_start(c.collection_id);
        end
        else
        begin
            case (c.op)
                OP_READY:    code = answer_ready(c.collection_id, c.tag_id);
                OP_ARM:      code = answer_arm(c.collection_id, c.slice_id, c.heading_bits);
                OP_ARMED:    code = answer_mark(c.collection_id, c.slice_id, c.tag_id, 1'b0);
                OP_COMPLETE: code = answer_mark(c.collection_id, c.slice_id, c.tag_id, 1'b1);
                OP_FINALIZE: code = answer_close(c.collection_id, DISP_FINALIZED);
                OP_CANCEL:   code = answer_close(c.collection_id, DISP_CANCELLED);
                default:     code = R_CONFLICT;
            endcase
        end
        // any answered command, and any other command, drops the staged run
        sh_stage_count = 0;
        sh_stage_over  = 1'b0;
        r.result = code;
        r.phase  = sh_phase;
        return 1'b1;
    endfunction

    // Driver: hold start/cmd steady until the transfer, idle in short bursts.
    int   idle_left;
    logic sent;
    logic drive_next;
    rsp_t predicted;

    always @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            start     <= 1'b0;
            cmd       <= '0;
            idle_left = 0;
            shadow_reset();
        end
        else
        begin
            sent = start && !busy;
            if (sent)
            begin
                if (coord_predict(cmd, predicted))
                    rsp_expected.push_back(predicted);
                void'(cmd_pending.pop_front());
                void'(hold_pending.pop_front());
            end
            drive_next = 1'b0;
            if (!sent && start)
                drive_next = 1'b1;       // still waiting on busy: keep offering
            else if (idle_left > 0)
                idle_left--;
            else if (cmd_pending.size() > 0)
            begin
                if (hold_pending[0] && (rsp_expected.size() != 0 || busy || sent))
                    drive_next = 1'b0;   // drain all answers first
                else if (cmd_pending.size() > QuietTail && $urandom_range(0, 7) == 0)
                    idle_left = $urandom_range(0, 2);
                else
                    drive_next = 1'b1;
            end
            start <= drive_next;
            if (drive_next)
                cmd <= cmd_pending[0];
        end
    end

    // Monitor: every answer is present for exactly one cycle.
    always @(posedge clk)
    begin
        if (rst_n && done)
        begin
            if (rsp_expected.size() == 0)
            begin
                $display("%0t: unexpected answer result=%0d phase=%0d",
                         $time, rsp.result, rsp.phase);
                fail_count++;
            end
            else
            begin
                predicted = rsp_expected.pop_front();
                if (rsp.result !== predicted.result)
                begin
                    $display("%0t: result mismatch expected=%0d actual=%0d",
                             $time, predicted.result, rsp.result);
                    fail_count++;
                end
                if (rsp.phase !== predicted.phase)
                begin
                    $display("%0t: phase mismatch expected=%0d actual=%0d",
                             $time, predicted.phase, rsp.phase);
                    fail_count++;
                end
            end
        end
    end

    // Watchdog: count cycles in which neither side transfers anything.
    always @(posedge clk)
    begin
        if (!rst_n || (start && !busy) || done)
            stall_cycles <= 0;
        else if (cmd_pending.size() != 0 || rsp_expected.size() != 0)
        begin
            if (stall_cycles >= StallLimit)
            begin
                $display("collection_slice_coordinator_top test failed");
                $finish;
            end
            stall_cycles <= stall_cycles + 1;
        end
    end

    task automatic push_cmd(logic [2:0] op, logic [31:0] cid, logic [31:0] slice,
                            logic [31:0] tag, logic present, logic last_item,
                            logic [31:0] heading, bit hold = 1'b0);
        cmd_t c;
        c.op            = op;
        c.collection_id = cid;
        c.slice_id      = slice;
        c.tag_id        = tag;
        c.tag_present   = present;
        c.last          = last_item;
        c.heading_bits  = heading;
        cmd_pending.push_back(c);
        hold_pending.push_back(hold);
    endtask

    task automatic push_noise();
        push_cmd(3'($urandom_range(0, 7)), $urandom(), $urandom(), $urandom(),
                 1'($urandom_range(0, 1)), 1'($urandom_range(0, 1)), $urandom());
    endtask

    // One collection from start to close. Mostly well formed; jitter adds
    // repeats, stale ids, strays and out-of-order slices.
    task automatic run_collection(logic [31:0] cid, int ntags, int nslices,
                                  logic [2:0] close_op, int jitter);
        logic [31:0] tags[$];
        logic [31:0] heading;
        int          reps;
        for (int i = 0; i < ntags; i++)
            tags.push_back((i > 0 && $urandom_range(0, 9) == 0) ? tags[i - 1] : $urandom());
        reps = ($urandom_range(0, 99) < jitter) ? 2 : 1;
        for (int r = 0; r < reps; r++)
        begin
            if (ntags == 0)
                push_cmd(OP_START, cid, $urandom(), $urandom(), 1'b0, 1'b1, $urandom());
            for (int i = 0; i < ntags; i++)
            begin
                if ($urandom_range(0, 9) == 0)
                    push_cmd(OP_START, cid, $urandom(), $urandom(), 1'b0, 1'b0, $urandom());
                push_cmd(OP_START, cid, $urandom(), tags[i], 1'b1, i == ntags - 1, $urandom());
            end
        end
        tags.shuffle();
        foreach (tags[i])
        begin
            if ($urandom_range(0, 99) < jitter)
                push_cmd(OP_READY, $urandom_range(0, 1) ? cid : $urandom(), 0,
                         $urandom_range(0, 1) ? tags[i] : $urandom(), 1'b0, 1'b0, 0);
            push_cmd(OP_READY, cid, $urandom(), tags[i], 1'b0, 1'b0, $urandom());
        end
        for (int s = 1; s <= nslices; s++)
        begin
            heading = $urandom_range(0, 3) == 0 ? {1'($urandom_range(0, 1)), 31'd0}
                                                : $urandom();
            if ($urandom_range(0, 99) < jitter)
                push_cmd(OP_ARM, cid, s + $urandom_range(0, 2) - 1, 0, 1'b0, 1'b0, heading);
            push_cmd(OP_ARM, cid, s, $urandom(), 1'b0, 1'b0, heading);
            if ($urandom_range(0, 99) < jitter)
                push_cmd(OP_ARM, cid, s, 0, 1'b0, 1'b0, $urandom_range(0, 1) ? heading : ~heading);
            foreach (tags[i])
            begin
                push_cmd(OP_ARMED, cid, s, tags[i], 1'b0, 1'b0, $urandom());
                if ($urandom_range(0, 99) < jitter)
                    push_cmd($urandom_range(0, 1) ? OP_ARMED : OP_COMPLETE,
                             $urandom_range(0, 3) ? cid : $urandom(),
                             $urandom_range(0, 1) ? s : $urandom(),
                             $urandom_range(0, 1) ? tags[i] : $urandom(), 1'b0, 1'b0, 0);
            end
            foreach (tags[i])
                push_cmd(OP_COMPLETE, cid, s, tags[i], 1'b0, 1'b0, $urandom());
            if ($urandom_range(0, 99) < jitter)
                push_cmd(OP_ARM, cid, s, 0, 1'b0, 1'b0, heading);
        end
        push_cmd(close_op, cid, $urandom(), $urandom(), 1'b0, 1'b0, $urandom());
        if ($urandom_range(0, 99) < jitter)
            push_cmd($urandom_range(0, 1) ? OP_FINALIZE : OP_CANCEL, cid, 0, 0, 1'b0, 1'b0, 0);
    endtask

    int ntags;

    initial
    begin
        rst_n = 1'b0;

        // Directed: closes after reset, empty and zero-id starts, unused op, a
        // start run broken by another command, a short full lifecycle with extreme
        // ids, then an overflowing start and a full-size collection.
        push_cmd(OP_FINALIZE, 32'd0, 0, 0, 1'b0, 1'b0, 0);
        push_cmd(OP_CANCEL, 32'hFFFF_FFFF, 0, 0, 1'b0, 1'b0, 0);
        push_cmd(OP_START, 32'd5, 0, 0, 1'b0, 1'b1, 0);
        push_cmd(OP_START, 32'd0, 0, 32'd9, 1'b1, 1'b1, 0);
        push_cmd(3'd7, 32'hFFFF_FFFF, 32'hFFFF_FFFF, 32'hFFFF_FFFF, 1'b1, 1'b1, 32'hFFFF_FFFF);
        push_cmd(OP_START, 32'd7, 0, 32'd1, 1'b1, 1'b0, 0);
        push_cmd(OP_READY, 32'd7, 0, 32'd1, 1'b0, 1'b0, 0);
        push_cmd(OP_START, 32'd7, 0, 32'd2, 1'b1, 1'b1, 0);
        push_cmd(OP_CANCEL, 32'd7, 0, 0, 1'b0, 1'b0, 0);
        run_collection(32'hFFFF_FFFF, 1, 1, OP_FINALIZE, 0);
        push_cmd(OP_CANCEL, 32'hFFFF_FFFF, 0, 0, 1'b0, 1'b0, 0);
        run_collection(32'h8000_0001, 17, 0, OP_CANCEL, 0);
        run_collection(32'h0000_0003, 16, 1, OP_FINALIZE, 0);

        // Random: mostly whole collections, small tag sets, some noise.
        while (cmd_pending.size() < RandItems)
        begin
            case ($urandom_range(0, 19))
                0:       ntags = 0;
                1:       ntags = $urandom_range(15, 18);
                default: ntags = $urandom_range(1, 4);
            endcase
            // now and then a cancel waits for a fully drained block
            if (hold_pending.size() > 0 && $urandom_range(0, 9) == 0)
                push_cmd(OP_CANCEL, $urandom(), 0, 0, 1'b0, 1'b0, 0, 1'b1);
            run_collection($urandom_range(0, 15) == 0 ? 32'd0 : $urandom(), ntags,
                           $urandom_range(0, 3), $urandom_range(0, 1) ? OP_FINALIZE : OP_CANCEL,
                           $urandom_range(0, 40));
            for (int n = $urandom_range(0, 3); n > 0; n--)
                push_noise();
        end
        hold_pending[60] = 1'b1;

        repeat (12) @(posedge clk);
        rst_n <= 1'b1;

        while (cmd_pending.size() != 0 || rsp_expected.size() != 0)
            @(posedge clk);
        repeat (DrainWait) @(posedge clk);

        if (fail_count == 0)
            $display("collection_slice_coordinator_top test passed");
        else
            $display("collection_slice_coordinator_top test failed");
        $finish;
    end

endmodule

`default_nettype wire
